FILE: rtl/core/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants, types and constant tables of the tone beep sequencer:
// note record, queue status, sine quarter-wave table, gain curve and the
// split tables that turn hertz and milliseconds into phase steps and counts.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // Rates and sizes
    localparam int TICK_RATE    = 16000;
    localparam int QUEUE_NOTES  = 8;
    localparam int SINE_ENTRIES = 1024;   // power of two
    localparam int MS_PER_S     = 1000;

    // Field widths
    localparam int FREQ_W   = 16;
    localparam int MS_W     = 16;
    localparam int SAMPLE_W = 15;
    localparam int VOL_W    = 7;
    localparam int GAIN_W   = 14;
    localparam int MAG_W    = 15;          // Q0.15 magnitude
    localparam int PHASE_W  = 32;
    localparam int LEFT_W   = 22;

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = VOL_W;

    // Volume and gain
    localparam int VOL_MAX   = 100;
    localparam int VOL_RESET = 50;
    localparam int GAIN_FULL = 16000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_PEAK = SAMPLE_W'(GAIN_FULL);

    // Derived sizes
    localparam int QIDX_W     = (QUEUE_NOTES > 1) ? $clog2(QUEUE_NOTES) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_NOTES + 1);
    localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);
    localparam int SINE_QTR   = SINE_ENTRIES / 4;
    localparam int QTR_W      = $clog2(SINE_QTR);
    localparam int PH_REM_W   = $clog2(TICK_RATE);
    localparam int MS_REM_W   = $clog2(MS_PER_S);
    localparam int SPLIT_W    = 8;
    localparam int SPLIT_N    = 1 << SPLIT_W;
    localparam int VOL_N      = 1 << VOL_W;

    // Series constants for the sine table build (Q30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Item kinds and register indexes
    typedef enum logic [IN_TUSER_W-1:0] {
        OP_NOTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLUME = 2'd0,
        REG_MUTE   = 2'd1
    } t_cfg_reg;

    // One queued note
    typedef struct packed {
        logic [MS_W-1:0]   gap;
        logic [MS_W-1:0]   dur;
        logic [FREQ_W-1:0] freq;
    } t_note;

    // Queue status towards the voice and the result logic
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Table types
    typedef logic [SPLIT_N-1:0][PHASE_W-1:0]  t_ph_q_tab;
    typedef logic [SPLIT_N-1:0][PH_REM_W-1:0] t_ph_r_tab;
    typedef logic [SPLIT_N-1:0][LEFT_W-1:0]   t_ms_q_tab;
    typedef logic [SPLIT_N-1:0][MS_REM_W-1:0] t_ms_r_tab;
    typedef logic [SINE_QTR:0][MAG_W-1:0]     t_sine_tab;
    typedef logic [VOL_N-1:0][GAIN_W-1:0]     t_gain_tab;

    // Phase step split: upper byte weighs 2^40, lower byte 2^32 plus half a
    // sample rate for rounding. Quotient and remainder per byte.
    function automatic t_ph_q_tab build_ph_q(input logic upper);
        t_ph_q_tab   tab;
        logic [63:0] v;
        logic [63:0] q;
        for (int i = 0; i < SPLIT_N; i++) begin
            v = upper ? (64'(i) << 40) : ((64'(i) << 32) + 64'(TICK_RATE / 2));
            q = v / 64'(TICK_RATE);
            tab[i] = q[PHASE_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_ph_r_tab build_ph_r(input logic upper);
        t_ph_r_tab   tab;
        logic [63:0] v;
        logic [63:0] r;
        for (int i = 0; i < SPLIT_N; i++) begin
            v = upper ? (64'(i) << 40) : ((64'(i) << 32) + 64'(TICK_RATE / 2));
            r = v % 64'(TICK_RATE);
            tab[i] = r[PH_REM_W-1:0];
        end
        return tab;
    endfunction

    // Millisecond to sample count split, same scheme over 1000
    function automatic t_ms_q_tab build_ms_q(input logic upper);
        t_ms_q_tab   tab;
        logic [63:0] v;
        logic [63:0] q;
        for (int i = 0; i < SPLIT_N; i++) begin
            v = (upper ? (64'(i) << SPLIT_W) : 64'(i)) * 64'(TICK_RATE);
            q = v / 64'(MS_PER_S);
            tab[i] = q[LEFT_W-1:0];
        end
        return tab;
    endfunction

    function automatic t_ms_r_tab build_ms_r(input logic upper);
        t_ms_r_tab   tab;
        logic [63:0] v;
        logic [63:0] r;
        for (int i = 0; i < SPLIT_N; i++) begin
            v = (upper ? (64'(i) << SPLIT_W) : 64'(i)) * 64'(TICK_RATE);
            r = v % 64'(MS_PER_S);
            tab[i] = r[MS_REM_W-1:0];
        end
        return tab;
    endfunction

    // sin(x) in Q30 for 0 <= x <= pi/2, seven Taylor terms
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Quarter wave magnitudes, entries 0 to SINE_QTR inclusive
    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] mag;
        for (int j = 0; j <= SINE_QTR; j++) begin
            r   = (64'(j) << 30) / 64'(SINE_QTR);
            x   = (r * HALF_PI_Q30) >> 30;
            s   = sin_q30(x);
            mag = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            tab[j] = mag[MAG_W-1:0];
        end
        return tab;
    endfunction

    // Gain curve round(16000*sqrt(v/100)), volumes above the top clamp
    function automatic t_gain_tab build_gain();
        t_gain_tab   tab;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] b;
        int          vv;
        for (int v = 0; v < VOL_N; v++) begin
            vv = (v > VOL_MAX) ? VOL_MAX : v;
            m  = 64'(GAIN_FULL) * 64'(GAIN_FULL) / 64'(VOL_MAX) * 64'(vv);
            r  = 64'd0;
            b  = 64'd1 << 40;
            while (b > m) begin
                b = b >> 2;
            end
            while (b != 64'd0) begin
                if (m >= r + b) begin
                    m = m - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (m > r) begin
                r = r + 64'd1;
            end
            tab[v] = r[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_ph_q_tab PH_HI_Q   = build_ph_q(1'b1);
    localparam t_ph_q_tab PH_LO_Q   = build_ph_q(1'b0);
    localparam t_ph_r_tab PH_HI_R   = build_ph_r(1'b1);
    localparam t_ph_r_tab PH_LO_R   = build_ph_r(1'b0);
    localparam t_ms_q_tab MS_HI_Q   = build_ms_q(1'b1);
    localparam t_ms_q_tab MS_LO_Q   = build_ms_q(1'b0);
    localparam t_ms_r_tab MS_HI_R   = build_ms_r(1'b1);
    localparam t_ms_r_tab MS_LO_R   = build_ms_r(1'b0);
    localparam t_sine_tab SINE_ROM  = build_sine();
    localparam t_gain_tab GAIN_ROM  = build_gain();

    // round(freq*2^32/TICK_RATE) mod 2^32: two byte lookups, one carry fix
    function automatic logic [PHASE_W-1:0] freq_to_step(input logic [FREQ_W-1:0] f);
        logic [PH_REM_W:0]  rsum;
        logic [PHASE_W-1:0] q;
        q    = PH_HI_Q[f[FREQ_W-1 -: SPLIT_W]] + PH_LO_Q[f[SPLIT_W-1:0]];
        rsum = {1'b0, PH_HI_R[f[FREQ_W-1 -: SPLIT_W]]} + {1'b0, PH_LO_R[f[SPLIT_W-1:0]]};
        return q + PHASE_W'(rsum >= (PH_REM_W + 1)'(TICK_RATE));
    endfunction

    // floor(TICK_RATE*ms/1000)
    function automatic logic [LEFT_W-1:0] ms_to_samples(input logic [MS_W-1:0] ms);
        logic [MS_REM_W:0] rsum;
        logic [LEFT_W-1:0] q;
        q    = MS_HI_Q[ms[MS_W-1 -: SPLIT_W]] + MS_LO_Q[ms[SPLIT_W-1:0]];
        rsum = {1'b0, MS_HI_R[ms[MS_W-1 -: SPLIT_W]]} + {1'b0, MS_LO_R[ms[SPLIT_W-1:0]]};
        return q + LEFT_W'(rsum >= (MS_REM_W + 1)'(MS_PER_S));
    endfunction

endpackage

FILE: rtl/core/tbs_note_queue.sv
// ----------------------------------------------------------------------------
// tbs_note_queue
// Circular note queue in flip-flops. Head entry is always visible; a push
// on a full queue is dropped by the caller.
// ----------------------------------------------------------------------------
module tbs_note_queue
    import tbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_note   i_note,
    input  logic    i_pop,
    output t_note   o_head,
    output t_q_stat o_stat
);

    t_note              r_mem [QUEUE_NOTES];
    logic [QIDX_W-1:0]  r_head, n_head;
    logic [QIDX_W-1:0]  r_tail, n_tail;
    logic [QCNT_W-1:0]  r_count, n_count;

    // Pointer wrap and fill count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == QIDX_W'(QUEUE_NOTES - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_pop) begin
            n_head  = (r_head == QIDX_W'(QUEUE_NOTES - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Note storage, no reset: entries are read only after being written
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_note;
        end
    end

    assign o_head       = r_mem[r_head];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_NOTES));

endmodule

FILE: rtl/core/tbs_voice.sv
// ----------------------------------------------------------------------------
// tbs_voice
// Tone voice: phase accumulator, tone and gap counters and the sample path
// (quarter-wave sine lookup times note gain). Starts the next queued note
// on a tick that finds the voice idle.
// ----------------------------------------------------------------------------
module tbs_voice
    import tbs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tick,
    input  t_note                      i_head,
    input  t_q_stat                    i_q_stat,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic                       i_silent,
    output logic                       o_pop,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_playing,
    output logic                       o_tone_busy
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] r_step, n_step;
    logic [LEFT_W-1:0]  r_tone_left, n_tone_left;
    logic [LEFT_W-1:0]  r_gap_left, n_gap_left;
    logic [GAIN_W-1:0]  r_gain, n_gain;

    logic                      start;
    logic [PHASE_W-1:0]        eff_phase;
    logic [PHASE_W-1:0]        eff_step;
    logic [LEFT_W-1:0]         eff_tone;
    logic [LEFT_W-1:0]         eff_gap;
    logic [GAIN_W-1:0]         eff_gain;
    logic [SINE_IDX_W-1:0]     sine_idx;
    logic [1:0]                quad;
    logic [QTR_W:0]            rom_idx;
    logic [MAG_W-1:0]          mag;
    logic [GAIN_W+MAG_W-1:0]   prod;
    logic [SAMPLE_W-1:0]       prod_mag;

    // Note start: idle voice and a note waiting
    assign start = (r_tone_left == '0) && (r_gap_left == '0) && !i_q_stat.empty;

    // Values seen by this tick, freshly loaded on a note start
    always_comb begin
        if (start) begin
            eff_phase = '0;
            eff_step  = freq_to_step(i_head.freq);
            eff_tone  = i_silent ? '0 : ms_to_samples(i_head.dur);
            eff_gap   = ms_to_samples(i_head.gap);
            eff_gain  = i_gain;
        end else begin
            eff_phase = r_phase;
            eff_step  = r_step;
            eff_tone  = r_tone_left;
            eff_gap   = r_gap_left;
            eff_gain  = r_gain;
        end
    end

    // Sine lookup by quadrant, magnitude scaled by gain, truncated to zero
    always_comb begin
        sine_idx = eff_phase[PHASE_W-1 -: SINE_IDX_W];
        quad     = sine_idx[SINE_IDX_W-1 -: 2];
        rom_idx  = quad[0] ? ((QTR_W + 1)'(SINE_QTR) - {1'b0, sine_idx[QTR_W-1:0]})
                           : {1'b0, sine_idx[QTR_W-1:0]};
        mag      = SINE_ROM[rom_idx];
        prod     = {{MAG_W{1'b0}}, eff_gain} * {{GAIN_W{1'b0}}, mag};
        prod_mag = SAMPLE_W'(prod[GAIN_W+MAG_W-1:MAG_W]);
    end

    // Counter and phase advance for one tick
    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_tone_left = r_tone_left;
        n_gap_left  = r_gap_left;
        n_gain      = r_gain;
        if (i_tick) begin
            n_step     = eff_step;
            n_gain     = eff_gain;
            n_gap_left = eff_gap;
            n_phase    = eff_phase;
            if (eff_tone != '0) begin
                n_phase     = eff_phase + eff_step;
                n_tone_left = eff_tone - 1'b1;
            end else begin
                n_tone_left = '0;
                if (eff_gap != '0) begin
                    n_gap_left = eff_gap - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_tone_left <= '0;
            r_gap_left  <= '0;
            r_gain      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_tone_left <= n_tone_left;
            r_gap_left  <= n_gap_left;
            r_gain      <= n_gain;
        end
    end

    // Tick result
    assign o_pop       = i_tick && start;
    assign o_playing   = (eff_tone != '0);
    assign o_sample    = (eff_tone == '0) ? '0 : (quad[1] ? -prod_mag : prod_mag);
    assign o_tone_busy = (r_tone_left != '0);

endmodule

FILE: rtl/core/tone_beep_sequencer_top.sv
// ----------------------------------------------------------------------------
// tone_beep_sequencer_top
// Queued tone generator: notes of frequency, tone length and gap length are
// queued; each tick transaction returns one signed audio sample.
//
//  channel  | direction | payload (low bit first)
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata: freq_hz, dur_ms, gap_ms; tuser: op
//  m_axis   | out       | tdata: sample (zero padded); tuser: playing, full
//  cfg      | in        | index 0 volume (clamped to 100), index 1 mute
//
// One transaction per clock while m_axis_tready stays high; a result is offered
// after its transaction passes the input register and then the result register.
// The critical path is the sine quarter-wave lookup feeding the 14x15 gain
// multiplier.
// Synchronous active-low reset; no clearing pass, the queue storage is
// never read before it is written. A stalled result holds in the result
// register while one more input transaction waits in the input register.
// ----------------------------------------------------------------------------
module tone_beep_sequencer_top
    import tbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // freq_hz[15:0], dur_ms[31:16], gap_ms[47:32]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // op[0]
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // sample[14:0], zero[15]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // playing[0], queue_full[1]
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic [VOL_W-1:0]  r_volume, n_volume;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              r_mute, n_mute;

    // Input stage
    logic              r_in_valid;
    logic              r_in_op;
    t_note             r_in_note;

    // Result stage
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                       r_out_playing, n_out_playing;
    logic                       r_out_full, n_out_full;

    logic                       advance;
    logic                       in_fire;
    logic                       is_tick;
    logic                       push;
    logic                       pop;
    t_note                      head;
    t_q_stat                    q_stat;
    logic signed [SAMPLE_W-1:0] voice_sample;
    logic                       voice_playing;
    logic                       tone_busy;
    logic [VOL_W-1:0]           vol_clamped;

    // Handshakes
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes
    assign vol_clamped = (i_cfg_data > VOL_W'(VOL_MAX)) ? VOL_W'(VOL_MAX) : i_cfg_data;

    always_comb begin
        n_volume = r_volume;
        n_gain   = r_gain;
        n_mute   = r_mute;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VOLUME: begin
                    n_volume = vol_clamped;
                    n_gain   = GAIN_ROM[vol_clamped];
                end
                REG_MUTE: begin
                    n_mute = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_W'(VOL_RESET);
            r_gain   <= GAIN_ROM[VOL_RESET];
            r_mute   <= 1'b0;
        end else begin
            r_volume <= n_volume;
            r_gain   <= n_gain;
            r_mute   <= n_mute;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_op   <= s_axis_tuser[0];
            r_in_note <= t_note'(s_axis_tdata);
        end
    end

    // Work for the transaction in the input register
    assign is_tick = (r_in_op == OP_TICK);
    assign push    = advance && !is_tick && !q_stat.full;

    tbs_note_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_note  (r_in_note),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tbs_voice u_voice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (advance && is_tick),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .i_gain      (r_gain),
        .i_silent    (r_mute || (r_volume == '0)),
        .o_pop       (pop),
        .o_sample    (voice_sample),
        .o_playing   (voice_playing),
        .o_tone_busy (tone_busy)
    );

    // Result selection
    always_comb begin
        if (is_tick) begin
            n_out_sample  = voice_sample;
            n_out_playing = voice_playing;
            n_out_full    = 1'b0;
        end else begin
            n_out_sample  = '0;
            n_out_playing = tone_busy;
            n_out_full    = q_stat.full;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sample  <= n_out_sample;
            r_out_playing <= n_out_playing;
            r_out_full    <= n_out_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W){1'b0}}, r_out_sample};
    assign m_axis_tuser  = {r_out_full, r_out_playing};

endmodule

FILE: rtl/core/tbs_checker.sv
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks on the result stream of the tone beep sequencer,
// bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker
    import tbs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Samples stay within the gain ceiling
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[SAMPLE_W-1:0]) <= SAMPLE_PEAK) &&
            ($signed(m_axis_tdata[SAMPLE_W-1:0]) >= -SAMPLE_PEAK))
        else $error("sample beyond gain ceiling");

    // Only a tone sample can be non-zero
    a_sound_needs_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[SAMPLE_W-1:0] != '0) |-> m_axis_tuser[0])
        else $error("non-zero sample outside a tone");

    // A rejected enqueue carries no audio
    a_full_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0))
        else $error("queue full result with audio");

endmodule

bind tone_beep_sequencer_top tbs_checker u_tbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
